### src/li_chao_min_hull_with_undo_unit_defines.svh
// Assertion macros shared by the Li Chao hull RTL.
`ifndef LI_CHAO_MIN_HULL_WITH_UNDO_UNIT_DEFINES_SVH
`define LI_CHAO_MIN_HULL_WITH_UNDO_UNIT_DEFINES_SVH
`ifndef SYNTH
// Checked while out of reset.
`define LCMH_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// Checked at every edge, reset included.
`define LCMH_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define LCMH_ASSERT(lbl, prop, msg)
`define LCMH_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

### src/lcmh_pkg.sv
// Types and constants for the Li Chao hull with undo.
package lcmh_pkg;

  localparam int unsigned MODE_W   = 3;
  localparam int unsigned COORD_W  = 32;
  localparam int unsigned ICPT_W   = 48;
  localparam int unsigned SLOPE_W  = 32;
  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned STATUS_W = 2;

  // Neutral line intercept (1e18), slope zero
  localparam logic signed [VALUE_W-1:0] NEUTRAL_INTERCEPT = 64'sd1000000000000000000;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR = 3'd0,
    MODE_LOAD  = 3'd1,
    MODE_ADD   = 3'd2,
    MODE_QUERY = 3'd3,
    MODE_UNDO  = 3'd4
  } mode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK   = 2'd0,
    STATUS_FULL = 2'd1,
    STATUS_MARK = 2'd2
  } status_e;

endpackage

### src/li_chao_min_hull_with_undo_unit.sv
// Li Chao tree over tabulated points with a change log and undo.
//
// Input channel (in_valid_i/in_ready_o) takes one request: mode, point
// index, coordinate, line and mark. Output channel (out_valid_o/out_ready_i)
// returns one result per request: min_value, change_count and status.
// One request is worked at a time; ready is high only while the sequencer
// idles, and a finished result waits in the output register.
// Load, a refused add and a bad undo go straight to the result; query
// and add walk the tree one level at a time, and undo pops one log
// entry at a time. Node and coordinate memory reads are registered,
// and the shared two-stage line compare unit is used up to three times
// per level. After reset the node memory is swept to the neutral line,
// one node written per cycle, while in_ready_o stays low; a clear
// request does the same sweep. When the receiver stalls, the result
// holds in the output register; the block may take the next request,
// but that result waits until the held one is taken.
`include "li_chao_min_hull_with_undo_unit_defines.svh"

module li_chao_min_hull_with_undo_unit #(
  parameter int unsigned POINT_COUNT = 1023,
  parameter int unsigned LOG_DEPTH   = 4096,
  localparam int unsigned IDX_W      = (POINT_COUNT > 1) ? $clog2(POINT_COUNT) : 1,
  localparam int unsigned CNT_W      = $clog2(LOG_DEPTH + 1)
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_ready_o,
  input  logic [lcmh_pkg::MODE_W-1:0]            mode_i,
  input  logic [IDX_W-1:0]                       point_index_i,
  input  logic signed [lcmh_pkg::COORD_W-1:0]    coordinate_i,
  input  logic signed [lcmh_pkg::ICPT_W-1:0]     line_intercept_i,
  input  logic signed [lcmh_pkg::SLOPE_W-1:0]    line_slope_i,
  input  logic [CNT_W-1:0]                       mark_i,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i,
  output logic signed [lcmh_pkg::VALUE_W-1:0]    min_value_o,
  output logic [CNT_W-1:0]                       change_count_o,
  output logic [lcmh_pkg::STATUS_W-1:0]          status_o
);

  localparam int unsigned NODE_SLOTS = 2 * POINT_COUNT + 2;
  localparam int unsigned NODE_W     = $clog2(NODE_SLOTS);
  localparam int unsigned LOG_AW     = $clog2(LOG_DEPTH);
  localparam int unsigned TREE_DEPTH = $clog2(POINT_COUNT + 1);

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_DONE,
    ST_ADD_RD, ST_ADD_MID, ST_ADD_MIDM, ST_ADD_MIDR,
    ST_ADD_LO, ST_ADD_LOM, ST_ADD_LOR, ST_ADD_HIM, ST_ADD_HIR,
    ST_Q_X, ST_Q_RD, ST_Q_OP, ST_Q_MUL, ST_Q_ACC,
    ST_U_RD, ST_U_WR
  } state_e;

  // Memories
  logic signed [63:0] node_ic_mem [NODE_SLOTS];
  logic signed [31:0] node_sl_mem [NODE_SLOTS];
  logic signed [31:0] coord_mem   [POINT_COUNT];
  logic [NODE_W-1:0]  log_node_mem [LOG_DEPTH];
  logic signed [63:0] log_ic_mem  [LOG_DEPTH];
  logic signed [31:0] log_sl_mem  [LOG_DEPTH];

  state_e             state_q;
  logic [NODE_W-1:0]  clr_q;
  logic               clr_reply_q;
  logic [CNT_W-1:0]   cnt_q, mark_q;
  logic [NODE_W-1:0]  node_q;
  logic [IDX_W-1:0]   lo_q, hi_q, qx_q;
  logic signed [63:0] a_q, ca_q, best_q, res_min_q;
  logic signed [31:0] b_q, cb_q, xhi_q, px_q;
  lcmh_pkg::status_e  res_status_q, status_q;
  logic               out_valid_q;
  logic signed [63:0] min_value_q;
  logic [CNT_W-1:0]   count_q;

  // Read data
  logic signed [63:0] node_ic_rd_q, log_ic_rd_q;
  logic signed [31:0] node_sl_rd_q, log_sl_rd_q, coord_rd_q;
  logic [NODE_W-1:0]  log_node_rd_q;

  // Compare unit: da + db * x, two stages
  logic signed [65:0] cmp_da_q, cmp_da2_q;
  logic signed [32:0] cmp_db_q;
  logic signed [31:0] cmp_x_q;
  logic signed [64:0] cmp_prod_q;
  logic signed [66:0] cmp_sum;
  logic               cmp_lt;

  // Port controls
  logic               node_we, log_we, coord_we, in_acc;
  logic [NODE_W-1:0]  node_waddr;
  logic signed [63:0] node_wic;
  logic signed [31:0] node_wsl;
  logic [IDX_W-1:0]   coord_raddr, qx, mid;
  logic [IDX_W:0]     mid_sum;
  logic [NODE_W:0]    child_l, child_r;
  logic               child_l_ok, child_r_ok, room_short;
  logic signed [63:0] q_v, best_nxt;

  assign in_ready_o     = (state_q == ST_IDLE);
  assign in_acc         = in_valid_i && in_ready_o;
  assign out_valid_o    = out_valid_q;
  assign min_value_o    = min_value_q;
  assign change_count_o = count_q;
  assign status_o       = status_q;

  // Tree navigation helpers
  assign mid_sum    = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid        = mid_sum[IDX_W:1];
  assign child_l    = {node_q, 1'b0};
  assign child_r    = {node_q, 1'b1};
  assign child_l_ok = child_l < (NODE_W + 1)'(NODE_SLOTS);
  assign child_r_ok = child_r < (NODE_W + 1)'(NODE_SLOTS);
  assign qx         = (point_index_i < IDX_W'(POINT_COUNT)) ? point_index_i
                                                            : IDX_W'(POINT_COUNT - 1);
  assign room_short = (int'(cnt_q) + int'(TREE_DEPTH)) > int'(LOG_DEPTH);

  // Compare result and query value
  assign cmp_sum  = 67'(cmp_da2_q) + 67'(cmp_prod_q);
  assign cmp_lt   = cmp_sum[66];
  assign q_v      = cmp_sum[63:0];
  assign best_nxt = (q_v < best_q) ? q_v : best_q;

  // Coordinate read address
  always_comb begin
    case (state_q)
      ST_IDLE:     coord_raddr = qx;
      ST_ADD_MIDR: coord_raddr = lo_q;
      ST_ADD_LO:   coord_raddr = hi_q;
      default:     coord_raddr = mid;
    endcase
  end

  // Memory write controls
  assign coord_we = in_acc && (mode_i == lcmh_pkg::MODE_LOAD) &&
                    (point_index_i < IDX_W'(POINT_COUNT));
  assign log_we   = (state_q == ST_ADD_MIDR) && cmp_lt && (cnt_q < CNT_W'(LOG_DEPTH));

  always_comb begin
    node_we    = 1'b0;
    node_waddr = node_q;
    node_wic   = a_q;
    node_wsl   = b_q;
    case (state_q)
      ST_CLR: begin
        node_we    = 1'b1;
        node_waddr = clr_q;
        node_wic   = lcmh_pkg::NEUTRAL_INTERCEPT;
        node_wsl   = '0;
      end
      ST_ADD_MIDR: node_we = cmp_lt;
      ST_U_WR: begin
        node_we    = 1'b1;
        node_waddr = log_node_rd_q;
        node_wic   = log_ic_rd_q;
        node_wsl   = log_sl_rd_q;
      end
      default: ;
    endcase
  end

  // Node memory
  always_ff @(posedge clk_i) begin
    if (node_we) begin
      node_ic_mem[node_waddr] <= node_wic;
      node_sl_mem[node_waddr] <= node_wsl;
    end
    node_ic_rd_q <= node_ic_mem[node_q];
    node_sl_rd_q <= node_sl_mem[node_q];
  end

  // Coordinate memory
  always_ff @(posedge clk_i) begin
    if (coord_we) coord_mem[point_index_i] <= coordinate_i;
    coord_rd_q <= coord_mem[coord_raddr];
  end

  // Change log memory
  always_ff @(posedge clk_i) begin
    if (log_we) begin
      log_node_mem[LOG_AW'(cnt_q)] <= node_q;
      log_ic_mem[LOG_AW'(cnt_q)]   <= ca_q;
      log_sl_mem[LOG_AW'(cnt_q)]   <= cb_q;
    end
    log_node_rd_q <= log_node_mem[LOG_AW'(cnt_q - 1'b1)];
    log_ic_rd_q   <= log_ic_mem[LOG_AW'(cnt_q - 1'b1)];
    log_sl_rd_q   <= log_sl_mem[LOG_AW'(cnt_q - 1'b1)];
  end

  // Multiply stage of the compare unit
  always_ff @(posedge clk_i) begin
    cmp_prod_q <= 65'(cmp_db_q * cmp_x_q);
    cmp_da2_q  <= cmp_da_q;
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLR;
      clr_q       <= '0;
      clr_reply_q <= 1'b0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_CLR: begin
          if (clr_q == NODE_W'(NODE_SLOTS - 1)) begin
            state_q <= clr_reply_q ? ST_DONE : ST_IDLE;
          end else begin
            clr_q <= clr_q + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            res_min_q    <= '0;
            res_status_q <= lcmh_pkg::STATUS_OK;
            mark_q       <= mark_i;
            node_q       <= NODE_W'(1);
            lo_q         <= '0;
            hi_q         <= IDX_W'(POINT_COUNT - 1);
            qx_q         <= qx;
            a_q          <= 64'(line_intercept_i);
            b_q          <= line_slope_i;
            best_q       <= lcmh_pkg::NEUTRAL_INTERCEPT;
            state_q      <= ST_DONE;
            case (mode_i)
              lcmh_pkg::MODE_CLEAR: begin
                state_q     <= ST_CLR;
                clr_q       <= '0;
                clr_reply_q <= 1'b1;
                cnt_q       <= '0;
              end
              lcmh_pkg::MODE_ADD: begin
                if (room_short) res_status_q <= lcmh_pkg::STATUS_FULL;
                else state_q <= ST_ADD_RD;
              end
              lcmh_pkg::MODE_QUERY: state_q <= ST_Q_X;
              lcmh_pkg::MODE_UNDO: begin
                if (mark_i > cnt_q) res_status_q <= lcmh_pkg::STATUS_MARK;
                else state_q <= ST_U_RD;
              end
              default: ;
            endcase
          end
        end
        // Add: one tree level per pass
        ST_ADD_RD: state_q <= ST_ADD_MID;
        ST_ADD_MID: begin
          ca_q     <= node_ic_rd_q;
          cb_q     <= node_sl_rd_q;
          cmp_da_q <= 66'(a_q) - 66'(node_ic_rd_q);
          cmp_db_q <= 33'(b_q) - 33'(node_sl_rd_q);
          cmp_x_q  <= coord_rd_q;
          state_q  <= ST_ADD_MIDM;
        end
        ST_ADD_MIDM: state_q <= ST_ADD_MIDR;
        ST_ADD_MIDR: begin
          if (cmp_lt) begin
            if (cnt_q < CNT_W'(LOG_DEPTH)) cnt_q <= cnt_q + 1'b1;
            a_q  <= ca_q;
            b_q  <= cb_q;
            ca_q <= a_q;
            cb_q <= b_q;
          end
          state_q <= (lo_q == hi_q) ? ST_DONE : ST_ADD_LO;
        end
        ST_ADD_LO: begin
          cmp_da_q <= 66'(a_q) - 66'(ca_q);
          cmp_db_q <= 33'(b_q) - 33'(cb_q);
          cmp_x_q  <= coord_rd_q;
          state_q  <= ST_ADD_LOM;
        end
        ST_ADD_LOM: begin
          xhi_q   <= coord_rd_q;
          state_q <= ST_ADD_LOR;
        end
        ST_ADD_LOR: begin
          if (cmp_lt) begin
            if (mid == lo_q || !child_l_ok) begin
              state_q <= ST_DONE;
            end else begin
              node_q  <= child_l[NODE_W-1:0];
              hi_q    <= mid - 1'b1;
              state_q <= ST_ADD_RD;
            end
          end else begin
            cmp_x_q <= xhi_q;
            state_q <= ST_ADD_HIM;
          end
        end
        ST_ADD_HIM: state_q <= ST_ADD_HIR;
        ST_ADD_HIR: begin
          if (cmp_lt && child_r_ok) begin
            node_q  <= child_r[NODE_W-1:0];
            lo_q    <= mid + 1'b1;
            state_q <= ST_ADD_RD;
          end else begin
            state_q <= ST_DONE;
          end
        end
        // Query: fetch x, then accumulate the minimum down the path
        ST_Q_X: begin
          px_q    <= coord_rd_q;
          state_q <= ST_Q_OP;
        end
        ST_Q_RD: state_q <= ST_Q_OP;
        ST_Q_OP: begin
          cmp_da_q <= 66'(node_ic_rd_q);
          cmp_db_q <= 33'(node_sl_rd_q);
          cmp_x_q  <= px_q;
          state_q  <= ST_Q_MUL;
        end
        ST_Q_MUL: state_q <= ST_Q_ACC;
        ST_Q_ACC: begin
          best_q    <= best_nxt;
          res_min_q <= best_nxt;
          if (qx_q < mid && child_l_ok) begin
            node_q  <= child_l[NODE_W-1:0];
            hi_q    <= mid - 1'b1;
            state_q <= ST_Q_RD;
          end else if (mid < qx_q && child_r_ok) begin
            node_q  <= child_r[NODE_W-1:0];
            lo_q    <= mid + 1'b1;
            state_q <= ST_Q_RD;
          end else begin
            state_q <= ST_DONE;
          end
        end
        // Undo: pop one log entry per ST_U_RD/ST_U_WR pass
        ST_U_RD: begin
          if (cnt_q > mark_q) begin
            cnt_q   <= cnt_q - 1'b1;
            state_q <= ST_U_WR;
          end else begin
            state_q <= ST_DONE;
          end
        end
        ST_U_WR: state_q <= ST_U_RD;
        ST_DONE: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            min_value_q <= res_min_q;
            count_q     <= cnt_q;
            status_q    <= res_status_q;
            clr_reply_q <= 1'b0;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Assertions
  `LCMH_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CNT_W'(LOG_DEPTH), "log count beyond depth")
  `LCMH_ASSERT(a_swap_logged, (state_q == ST_ADD_MIDR) && cmp_lt |-> log_we, "swap not logged")
  `LCMH_ASSERT(a_full_status, out_valid_q && (status_q == lcmh_pkg::STATUS_FULL) |-> (int'(count_q) + int'(TREE_DEPTH) > int'(LOG_DEPTH)), "add refused with room")
  `LCMH_ASSERT(a_undo_pop, (state_q == ST_U_RD) && (cnt_q > mark_q) |=> (cnt_q == $past(cnt_q) - 1'b1), "undo pop lost")

endmodule

### dv/tb_top.sv
// Self-checking testbench for the Li Chao minimum hull with undo.
`timescale 1ns / 100ps

module tb_top;
  import lcmh_pkg::*;

  localparam int unsigned POINTS     = 1023;
  localparam int unsigned LOG_SLOTS  = 4096;
  localparam int unsigned NODES      = 2 * POINTS + 2;
  localparam int unsigned LEVELS     = 10;
  localparam int unsigned DRAIN_CYC  = 200;
  localparam longint unsigned CYCLE_LIMIT = 6000000;

  typedef struct packed {
    logic signed [VALUE_W-1:0] min_value;
    logic [12:0]               change_count;
    logic [STATUS_W-1:0]       status;
  } hull_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [MODE_W-1:0] mode_i = '0;
  logic [9:0] point_index_i = '0;
  logic signed [COORD_W-1:0] coordinate_i = '0;
  logic signed [ICPT_W-1:0] line_intercept_i = '0;
  logic signed [SLOPE_W-1:0] line_slope_i = '0;
  logic [12:0] mark_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic signed [VALUE_W-1:0] min_value_o;
  logic [12:0] change_count_o;
  logic [STATUS_W-1:0] status_o;

  li_chao_min_hull_with_undo_unit dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .mode_i, .point_index_i,
    .coordinate_i, .line_intercept_i, .line_slope_i, .mark_i,
    .out_valid_o, .out_ready_i, .min_value_o, .change_count_o, .status_o
  );

  // Shadow copy of the hull state
  logic signed [31:0] xs_tab [POINTS];
  logic signed [63:0] hull_icpt [NODES];
  logic signed [31:0] hull_slope [NODES];
  logic [10:0]        undo_node [LOG_SLOTS];
  logic signed [63:0] undo_icpt [LOG_SLOTS];
  logic signed [31:0] undo_slope [LOG_SLOTS];
  int unsigned        undo_cnt;

  hull_result_t pending_results[$];
  int unsigned  err_cnt = 0;
  int unsigned  in_idle_pct = 0;
  int unsigned  out_stall_pct = 0;
  longint unsigned cycle_cnt = 0;

  always #5 clk_i = ~clk_i;

  // Watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Receiver backpressure
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= out_stall_pct);
  end

  // Result checker
  always @(posedge clk_i) begin
    hull_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result: min_value %0d change_count %0d status %0d",
               min_value_o, change_count_o, status_o);
        err_cnt++;
      end else begin
        want = pending_results.pop_front();
        if (min_value_o !== want.min_value) begin
          $error("min_value: expected %0d actual %0d", want.min_value, min_value_o);
          err_cnt++;
        end
        if (change_count_o !== want.change_count) begin
          $error("change_count: expected %0d actual %0d", want.change_count,
                 change_count_o);
          err_cnt++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d actual %0d", want.status, status_o);
          err_cnt++;
        end
      end
    end
  end

  // Exact compare of two lines at x, wide enough to never overflow
  function automatic bit line_below(input logic signed [63:0] a1, input logic signed [63:0] b1,
                                    input logic signed [63:0] a2, input logic signed [63:0] b2,
                                    input logic signed [63:0] x);
    logic signed [127:0] wa1, wb1, wa2, wb2, wx;
    wa1 = a1; wb1 = b1; wa2 = a2; wb2 = b2; wx = x;
    return (wa1 + wb1 * wx) < (wa2 + wb2 * wx);
  endfunction

  function automatic logic signed [63:0] x_at(input int idx);
    if (idx < 0 || idx >= POINTS) return 64'sd0;
    return xs_tab[idx];
  endfunction

  function automatic void hull_reset();
    for (int i = 0; i < NODES; i++) begin
      hull_icpt[i] = NEUTRAL_INTERCEPT;
      hull_slope[i] = '0;
    end
    undo_cnt = 0;
  endfunction

  // Descend and swap winners; returns the status of the add
  function automatic logic [STATUS_W-1:0] hull_insert(input logic signed [63:0] a_in,
                                                      input logic signed [63:0] b_in);
    int node, lo, hi, mid;
    logic signed [63:0] a, b, ca, cb, ta, tb;
    node = 1; lo = 0; hi = POINTS - 1;
    a = a_in; b = b_in;
    if (LOG_SLOTS - undo_cnt < LEVELS) return STATUS_FULL;
    while (node < NODES && lo <= hi) begin
      mid = (lo + hi) >>> 1;
      ca = hull_icpt[node];
      cb = hull_slope[node];
      if (line_below(a, b, ca, cb, x_at(mid))) begin
        ta = a; tb = b;
        if (undo_cnt < LOG_SLOTS) begin
          undo_node[undo_cnt] = node;
          undo_icpt[undo_cnt] = ca;
          undo_slope[undo_cnt] = cb[31:0];
          undo_cnt++;
        end
        hull_icpt[node] = ta;
        hull_slope[node] = tb[31:0];
        a = ca; b = cb; ca = ta; cb = tb;
      end
      if (lo == hi) break;
      if (line_below(a, b, ca, cb, x_at(lo))) begin
        if (mid - 1 < lo) break;
        node = 2 * node;
        hi = mid - 1;
      end else if (line_below(a, b, ca, cb, x_at(hi))) begin
        node = 2 * node + 1;
        lo = mid + 1;
      end else begin
        break;
      end
    end
    return STATUS_OK;
  endfunction

  function automatic logic signed [63:0] hull_min_at(input int x);
    int node, lo, hi, mid;
    logic signed [63:0] best, v, px;
    node = 1; lo = 0; hi = POINTS - 1;
    best = NEUTRAL_INTERCEPT;
    px = x_at(x);
    while (node < NODES && lo <= hi) begin
      mid = (lo + hi) >>> 1;
      v = hull_icpt[node] + 64'(hull_slope[node]) * px;
      if (v < best) best = v;
      if (x < mid) begin
        node = 2 * node; hi = mid - 1;
      end else if (mid < x) begin
        node = 2 * node + 1; lo = mid + 1;
      end else begin
        break;
      end
    end
    return best;
  endfunction

  // Update the shadow state for one request and return its result
  function automatic hull_result_t hull_step(input logic [2:0] mode, input logic [9:0] pidx,
                                             input logic signed [31:0] coord,
                                             input logic signed [47:0] icpt,
                                             input logic signed [31:0] slope,
                                             input logic [12:0] mark);
    hull_result_t res;
    res = '0;
    case (mode)
      MODE_CLEAR: hull_reset();
      MODE_LOAD: if (pidx < POINTS) xs_tab[pidx] = coord;
      MODE_ADD: res.status = hull_insert(64'(icpt), 64'(slope));
      MODE_QUERY: res.min_value = hull_min_at((pidx < POINTS) ? int'(pidx) : POINTS - 1);
      MODE_UNDO: begin
        if (mark > undo_cnt) begin
          res.status = STATUS_MARK;
        end else begin
          while (undo_cnt > mark) begin
            undo_cnt--;
            hull_icpt[undo_node[undo_cnt]] = undo_icpt[undo_cnt];
            hull_slope[undo_node[undo_cnt]] = undo_slope[undo_cnt];
          end
        end
      end
      default: ;
    endcase
    res.change_count = undo_cnt[12:0];
    return res;
  endfunction

  // Send one request; valid stays up until the next send or a drain
  task automatic send_req(input logic [2:0] mode, input logic [9:0] pidx,
                          input logic signed [31:0] coord, input logic signed [47:0] icpt,
                          input logic signed [31:0] slope, input logic [12:0] mark);
    pending_results.push_back(hull_step(mode, pidx, coord, icpt, slope, mark));
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < in_idle_pct) @(posedge clk_i);
    end
    mode_i <= mode;
    point_index_i <= pidx;
    coordinate_i <= coord;
    line_intercept_i <= icpt;
    line_slope_i <= slope;
    mark_i <= mark;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  function automatic logic signed [47:0] rand_icpt();
    return 48'({$urandom, $urandom});
  endfunction

  function automatic logic signed [31:0] rand_slope();
    logic signed [31:0] s;
    do s = $urandom; while (s == 32'sh8000_0000);
    return s;
  endfunction

  // Fill the table with increasing coordinates spanning the full range
  task automatic test_load_table();
    longint v;
    for (int i = 0; i < POINTS; i++) begin
      v = -64'sd2147483648 + longint'(i) * 4198000 + $urandom_range(4000000);
      if (i == 0) v = -64'sd2147483648;
      if (i == POINTS - 1) v = 64'sd2147483647;
      send_req(MODE_LOAD, 10'(i), 32'(v), rand_icpt(), rand_slope(), 13'($urandom));
    end
    // out-of-range load is dropped
    send_req(MODE_LOAD, 10'd1023, 32'sh1234_5678, '0, '0, '0);
    drain();
  endtask

  // Field extremes, every mode but load, the special cases
  task automatic test_directed();
    send_req(MODE_QUERY, 10'd0, '0, '0, '0, '0);
    send_req(MODE_UNDO, '0, '0, '0, '0, 13'd1);
    send_req(MODE_ADD, '0, '0, 48'sh7FFF_FFFF_FFFF, 32'sh7FFF_FFFF, '0);
    send_req(MODE_ADD, '0, '0, 48'sh8000_0000_0000, -32'sh7FFF_FFFF, '0);
    send_req(MODE_ADD, '0, '0, 48'sh8000_0000_0000, 32'sh7FFF_FFFF, '0);
    send_req(MODE_ADD, '0, '0, 48'sh7FFF_FFFF_FFFF, -32'sh7FFF_FFFF, '0);
    send_req(MODE_ADD, '0, '0, 48'sd0, 32'sd0, '0);
    send_req(MODE_QUERY, 10'd0, '0, '0, '0, '0);
    send_req(MODE_QUERY, 10'd511, '0, '0, '0, '0);
    send_req(MODE_QUERY, 10'd1022, '0, '0, '0, '0);
    send_req(MODE_QUERY, 10'd1023, '0, '0, '0, '0);
    send_req(MODE_UNDO, '0, '0, '0, '0, 13'd4096);
    send_req(3'd5, 10'h3FF, 32'shFFFF_FFFF, 48'shFFFF_FFFF_FFFF, 32'shFFFF_FFFF, 13'h1FFF);
    send_req(3'd6, '0, '0, '0, '0, '0);
    send_req(3'd7, '0, '0, '0, '0, '0);
    send_req(MODE_UNDO, '0, '0, '0, '0, 13'(undo_cnt / 2));
    send_req(MODE_QUERY, 10'd0, '0, '0, '0, '0);
    send_req(MODE_UNDO, '0, '0, '0, '0, 13'd0);
    send_req(MODE_QUERY, 10'd1022, '0, '0, '0, '0);
    send_req(MODE_ADD, '0, '0, -48'sd5, 32'sd3, '0);
    send_req(MODE_CLEAR, '0, '0, '0, '0, '0);
    send_req(MODE_QUERY, 10'd700, '0, '0, '0, '0);
    drain();
  endtask

  // Add lines until the log refuses, then roll everything back
  task automatic test_log_full();
    logic [STATUS_W-1:0] last_status;
    int n;
    n = 0;
    last_status = STATUS_OK;
    while (last_status != STATUS_FULL && n < 4000) begin
      send_req(MODE_ADD, '0, '0, rand_icpt(), rand_slope(), '0);
      last_status = pending_results[$].status;
      n++;
    end
    send_req(MODE_ADD, '0, '0, rand_icpt(), rand_slope(), '0);
    send_req(MODE_QUERY, 10'($urandom_range(1022)), '0, '0, '0, '0);
    send_req(MODE_UNDO, '0, '0, '0, '0, 13'd4096);
    send_req(MODE_UNDO, '0, '0, '0, '0, 13'(undo_cnt - 7));
    send_req(MODE_UNDO, '0, '0, '0, '0, 13'd0);
    send_req(MODE_QUERY, 10'd300, '0, '0, '0, '0);
    drain();
  endtask

  // Mostly add and query with undo to valid marks; some noise
  task automatic test_random(input int unsigned n_items, input int unsigned idle_pct,
                             input int unsigned stall_pct);
    int unsigned r;
    logic [2:0] m;
    logic [12:0] mk;
    in_idle_pct = idle_pct;
    out_stall_pct = stall_pct;
    for (int unsigned i = 0; i < n_items; i++) begin
      r = $urandom_range(199);
      mk = 13'($urandom);
      if (r < 80) m = MODE_ADD;
      else if (r < 150) m = MODE_QUERY;
      else if (r < 172) begin
        m = MODE_UNDO;
        mk = 13'($urandom_range(undo_cnt));
      end else if (r < 178) m = MODE_UNDO;
      else if (r < 188) m = MODE_LOAD;
      else if (r < 197) m = 3'($urandom_range(7, 5));
      else m = MODE_CLEAR;
      send_req(m, 10'($urandom_range(1023)), 32'($urandom), rand_icpt(), rand_slope(), mk);
    end
    drain();
  endtask

  initial begin
    hull_reset();
    for (int i = 0; i < POINTS; i++) xs_tab[i] = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_load_table();
    test_directed();
    test_log_full();
    test_random(215, 0, 0);
    test_random(215, 82, 0);
    test_random(215, 0, 82);
    test_random(215, 14, 14);
    if (err_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
